FILE: rtl/bpig_pkg.sv
// Package for the bicubic patch index generator: shared types, codes and helpers.
`default_nettype none
package bpig_pkg;

    localparam int unsigned MAX_ACROSS      = 64;
    localparam int unsigned MAX_LENGTHWISE  = 64;
    localparam int unsigned POINTS_PER_SIDE = 4;

    localparam int unsigned SIZE_W  = 7;
    localparam int unsigned WRAP_W  = 2;
    localparam int unsigned CNT_W   = 6;
    localparam int unsigned INNER_W = 2;
    localparam int unsigned IDX_W   = 16;
    localparam int unsigned CFG_W   = 7;
    localparam int unsigned ADDR_W  = 2;

    // register indexes
    localparam logic [ADDR_W-1:0] REG_ACROSS     = 2'd0;
    localparam logic [ADDR_W-1:0] REG_LENGTHWISE = 2'd1;
    localparam logic [ADDR_W-1:0] REG_WRAP_MODE  = 2'd2;

    // wrap codes
    localparam logic [WRAP_W-1:0] WRAP_NONE  = 2'd0;
    localparam logic [WRAP_W-1:0] WRAP_LEFT  = 2'd1;
    localparam logic [WRAP_W-1:0] WRAP_RIGHT = 2'd2;

    localparam logic [INNER_W-1:0] LAST_INNER = INNER_W'(POINTS_PER_SIDE - 1);

    typedef struct packed {
        logic [CNT_W-1:0]   row;
        logic [CNT_W-1:0]   col;
        logic [INNER_W-1:0] inner;
    } count_t;

    typedef struct packed {
        logic last_row;
        logic last_col;
        logic last_inner;
    } flags_t;

    typedef struct packed {
        logic [SIZE_W-1:0] across;
        logic              left;
        logic              right;
    } geom_t;

    typedef struct packed {
        logic               last;
        logic [INNER_W-1:0] row_in_patch;
        logic [CNT_W-1:0]   grid_col;
        logic [CNT_W-1:0]   grid_row;
        logic [IDX_W-1:0]   corner_d;
        logic [IDX_W-1:0]   corner_c;
        logic [IDX_W-1:0]   corner_b;
        logic [IDX_W-1:0]   corner_a;
    } result_t;

    // zero acts as one, oversize saturates
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] max_v);
        logic [SIZE_W-1:0] r;
        if (v == '0) begin
            r = SIZE_W'(1);
        end else if (v > max_v) begin
            r = max_v;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/bpig_counter.sv
// Row, column and inner-row counters of the patch walk.
`default_nettype none
module bpig_counter (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         advance,
    input  wire logic                         restart,
    input  wire logic [bpig_pkg::CNT_W-1:0]   across_m1,
    input  wire logic [bpig_pkg::CNT_W-1:0]   lenwise_m1,
    output bpig_pkg::count_t                  cur,
    output bpig_pkg::flags_t                  flags
);
    import bpig_pkg::*;

    count_t count_reg, count_next;

    // restart takes effect on the item that carries it
    assign cur = restart ? '0 : count_reg;

    // counters beyond a shrunk size count as being at the last value
    assign flags.last_col   = cur.col >= across_m1;
    assign flags.last_row   = cur.row >= lenwise_m1;
    assign flags.last_inner = cur.inner >= LAST_INNER;

    always_comb begin
        count_next = cur;
        if (!flags.last_inner) begin
            count_next.inner = cur.inner + INNER_W'(1);
        end else begin
            count_next.inner = '0;
            if (!flags.last_col) begin
                count_next.col = cur.col + CNT_W'(1);
            end else begin
                count_next.col = '0;
                if (!flags.last_row) begin
                    count_next.row = cur.row + CNT_W'(1);
                end else begin
                    count_next.row = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (advance) begin
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/bpig_index.sv
// Control-point index arithmetic for one patch row.
`default_nettype none
module bpig_index (
    input  wire bpig_pkg::count_t   cnt,
    input  wire bpig_pkg::flags_t   flags,
    input  wire bpig_pkg::geom_t    geom,
    output bpig_pkg::result_t       res
);
    import bpig_pkg::*;

    logic [7:0]       three_across;
    logic [7:0]       stride;
    logic [7:0]       grid_r;
    logic [7:0]       three_col;
    logic [IDX_W-1:0] base;
    logic [IDX_W-1:0] col_idx;

    always_comb begin
        three_across = {geom.across, 1'b0} + {1'b0, geom.across};
        // one column is shared under either wrap
        stride    = three_across + ((geom.left || geom.right) ? 8'd0 : 8'd1);
        grid_r    = {6'd0, cnt.inner} + ({1'b0, cnt.row, 1'b0} + {2'b0, cnt.row});
        three_col = {1'b0, cnt.col, 1'b0} + {2'b0, cnt.col};
        base      = {8'd0, grid_r} * {8'd0, stride};
        col_idx   = base + {8'd0, three_col};

        res.corner_a = (geom.left && cnt.col == '0) ? base + {8'd0, three_across} : col_idx;
        res.corner_b = col_idx + IDX_W'(1);
        res.corner_c = col_idx + IDX_W'(2);
        res.corner_d = (geom.right && flags.last_col) ? base : col_idx + IDX_W'(3);

        res.grid_row     = cnt.row;
        res.grid_col     = cnt.col;
        res.row_in_patch = cnt.inner;
        res.last         = flags.last_row && flags.last_col && flags.last_inner;
    end

endmodule
`default_nettype wire

FILE: rtl/bezier_patch_index_generator.sv
// An input transfer's index row is registered and shown on the master side in the next cycle.
// Throughput: one index row per cycle; a new item is taken while the result
// register drains, so the only stall is a held result register.
// The index product r*stride is one 8x8 multiply between the counters and the result register.
// Reset (aresetn low, synchronous): counters to zero, sizes to one, no wrap, output empty.
`default_nettype none
module bezier_patch_index_generator (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [bpig_pkg::ADDR_W-1:0]   cfg_addr,
    input  wire logic [bpig_pkg::CFG_W-1:0]    cfg_wr_data,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,   // [0] restart, rest zero
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [15:0] corner_a, [31:16] corner_b, [47:32] corner_c, [63:48] corner_d,
    // [69:64] grid_row, [75:70] grid_col, [77:76] row_in_patch, [79:78] zero
    output logic [79:0]                        m_tdata,
    output logic                               m_tlast
);
    import bpig_pkg::*;

    logic [SIZE_W-1:0] across_reg;
    logic [SIZE_W-1:0] lenwise_reg;
    logic [WRAP_W-1:0] wrap_reg;
    logic              m_valid_reg;
    result_t           res_reg;

    logic [SIZE_W-1:0] across_eff;
    logic [SIZE_W-1:0] lenwise_eff;
    logic              s_xfer;
    count_t            cur;
    flags_t            flags;
    geom_t             geom;
    result_t           res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            across_reg  <= SIZE_W'(1);
            lenwise_reg <= SIZE_W'(1);
            wrap_reg    <= WRAP_NONE;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_ACROSS:     across_reg  <= cfg_wr_data;
                REG_LENGTHWISE: lenwise_reg <= cfg_wr_data;
                REG_WRAP_MODE:  wrap_reg    <= cfg_wr_data[WRAP_W-1:0];
                default: ;
            endcase
        end
    end

    assign across_eff  = clamp_size(across_reg, SIZE_W'(MAX_ACROSS));
    assign lenwise_eff = clamp_size(lenwise_reg, SIZE_W'(MAX_LENGTHWISE));

    assign geom.across = across_eff;
    assign geom.left   = wrap_reg == WRAP_LEFT;
    assign geom.right  = wrap_reg == WRAP_RIGHT;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_xfer   = s_tvalid && s_tready;

    bpig_counter u_counter (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (s_xfer),
        .restart    (s_tdata[0]),
        .across_m1  (CNT_W'(across_eff - SIZE_W'(1))),
        .lenwise_m1 (CNT_W'(lenwise_eff - SIZE_W'(1))),
        .cur        (cur),
        .flags      (flags)
    );

    bpig_index u_index (
        .cnt   (cur),
        .flags (flags),
        .geom  (geom),
        .res   (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_xfer) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, res_reg.row_in_patch, res_reg.grid_col, res_reg.grid_row,
                       res_reg.corner_d, res_reg.corner_c, res_reg.corner_b,
                       res_reg.corner_a};
    assign m_tlast  = res_reg.last;

    // restart yields the first row of the first patch
    a_restart_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && s_tdata[0] |=> m_tvalid && m_tdata[77:64] == 14'd0)
        else $error("restart did not produce the first row");

    // the final row is always the last row inside its patch
    a_last_inner: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[77:76] == LAST_INNER)
        else $error("last flagged before the last inner row");

    // after the final row the walk wraps to the origin
    a_wrap_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && res.last |=> cur == '0 || s_tdata[0])
        else $error("counters did not wrap after the final row");

    // a held result is not overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_tready |-> !s_xfer)
        else $error("input taken over a held result");

endmodule
`default_nettype wire
